/* rtl/core/aalp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalp_pkg
// Shared types and constants for the address allow-list prefilter.
// ----------------------------------------------------------------------------
package aalp_pkg;

   localparam int ADDR_W      = 32;
   localparam int OCTET_W     = 8;
   localparam int OCTETS      = 4;
   localparam int COUNT_DEPTH = 256;

   // request command codes
   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_CLEAR  = 2'd3
   } command_type;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DUP       = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_COUNT,
      ST_SEARCH,
      ST_UPDATE,
      ST_RESP
   } state_type;

   // table scan status
   typedef struct packed {
      logic done;
      logic hit;
      logic free_found;
   } scan_flags_type;

endpackage

/* rtl/core/aalp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module aalp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/aalp_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalp_scan
// Walks the address table one entry per cycle, compares each entry against
// the target and records the first match and the lowest free entry.
// ----------------------------------------------------------------------------
module aalp_scan import aalp_pkg::*; #(
   parameter int ENTRIES = 64,
   localparam int IW     = $clog2(ENTRIES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              entry_valid,
   input  logic [ADDR_W-1:0] entry_address,
   input  logic [ADDR_W-1:0] target,
   output logic [IW-1:0]     rd_addr,
   output logic [IW-1:0]     hit_idx,
   output logic [IW-1:0]     free_idx,
   output scan_flags_type    flags
);

   logic [IW:0]   scan_ff, scan_in;
   logic          run_ff, run_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic          free_ff, free_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic          done_ff, done_in;
   logic          issue;
   logic          hit_now;
   logic          last_now;
   logic          finish;

   // read issue and compare of the entry read in the previous cycle
   always_comb begin
      issue    = run_ff && (scan_ff != (IW+1)'(ENTRIES));
      hit_now  = chk_vld_ff && entry_valid && (entry_address == target);
      last_now = chk_vld_ff && (chk_idx_ff == IW'(ENTRIES - 1));
      finish   = run_ff && (hit_now || last_now);
   end

   // next scan state
   always_comb begin
      scan_in     = scan_ff;
      run_in      = run_ff;
      chk_vld_in  = chk_vld_ff;
      chk_idx_in  = chk_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      done_in     = done_ff;
      if (start) begin
         scan_in    = '0;
         run_in     = 1'b1;
         chk_vld_in = 1'b0;
         hit_in     = 1'b0;
         free_in    = 1'b0;
         done_in    = 1'b0;
      end else if (run_ff) begin
         scan_in    = issue ? scan_ff + 1'b1 : scan_ff;
         chk_vld_in = issue && !finish;
         chk_idx_in = scan_ff[IW-1:0];
         if (hit_now) begin
            hit_in     = 1'b1;
            hit_idx_in = chk_idx_ff;
         end
         // lowest invalid entry is the slot for an add
         if (chk_vld_ff && !entry_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
         if (finish) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         chk_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
      end else begin
         run_ff     <= run_in;
         chk_vld_ff <= chk_vld_in;
         done_ff    <= done_in;
         hit_ff     <= hit_in;
         free_ff    <= free_in;
      end
   end

   // index registers
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      chk_idx_ff  <= chk_idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   assign rd_addr  = scan_ff[IW-1:0];
   assign hit_idx  = hit_idx_ff;
   assign free_idx = free_idx_ff;

   // flags packed as done, hit, free_found from the top bit down
   assign flags = {done_ff, hit_ff, free_ff};

endmodule

/* rtl/core/address_allow_list_prefilter.sv */
`timescale 1ns / 1ps
// A lookup, add or delete passes the LOAD, COUNT, SEARCH and UPDATE states before its response.
// A lookup whose octet counters fail the prefilter still walks the table.
// Clear wipes max(TABLE_ENTRIES, 256) entries in a sweep of one entry a cycle.
// The block takes one item at a time; the table scan port reads one entry per cycle
// while it searches for a lookup, add or delete.
// Reset: synchronous; afterwards a max(TABLE_ENTRIES, 256) entry wipe runs with req_tready low.
// ----------------------------------------------------------------------------
// address_allow_list_prefilter
// Exact-match IPv4 allow list with four per-octet counting prefilters,
// sequenced over a shared table scan unit.
// ----------------------------------------------------------------------------
module address_allow_list_prefilter import aalp_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // command[1:0], address[33:2], zero pad
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // authorized[0], prefilter_pass[1], status[3:2], zero pad
);

   localparam int IW    = $clog2(TABLE_ENTRIES);
   localparam int CW    = $clog2(TABLE_ENTRIES + 1);
   localparam int SWEEP = (TABLE_ENTRIES > COUNT_DEPTH) ? TABLE_ENTRIES : COUNT_DEPTH;
   localparam int SW    = $clog2(SWEEP);
   localparam int CAW   = $clog2(COUNT_DEPTH);

   state_type         state_ff, state_in;
   command_type       cmd_ff, cmd_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [SW-1:0]     clr_ff, clr_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic [CW-1:0]     cnt_ff [OCTETS];
   logic [CW-1:0]     cnt_in [OCTETS];
   logic              pass_ff, pass_in;
   logic              rsp_auth_ff, rsp_auth_in;
   logic              rsp_pass_ff, rsp_pass_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              accept;
   logic              all_nz;
   logic              clr_last;
   logic              scan_start;
   logic [OCTET_W-1:0] octet [OCTETS];

   // table memory: valid bit over address
   logic              tbl_we;
   logic [IW-1:0]     tbl_waddr;
   logic [ADDR_W:0]   tbl_wdata;
   logic [IW-1:0]     tbl_raddr;
   logic [ADDR_W:0]   tbl_rdata;

   // counter memories
   logic              cnt_we;
   logic [CAW-1:0]    cnt_addr [OCTETS];
   logic [CW-1:0]     cnt_wdata [OCTETS];
   logic [CW-1:0]     cnt_rdata [OCTETS];

   scan_flags_type    scan_flags;
   logic [IW-1:0]     hit_idx;
   logic [IW-1:0]     free_idx;

   // octet split, first octet in the top byte
   always_comb begin
      for (int k = 0; k < OCTETS; k++) begin
         octet[k] = addr_ff[ADDR_W-1-OCTET_W*k -: OCTET_W];
      end
   end

   // prefilter test and sweep end
   always_comb begin
      all_nz = 1'b1;
      for (int k = 0; k < OCTETS; k++) begin
         if (cnt_rdata[k] == '0) begin
            all_nz = 1'b0;
         end
      end
      clr_last = (clr_ff == SW'(SWEEP - 1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (command_type'(req_tdata[1:0]) == CMD_CLEAR) ? ST_CLEAR : ST_LOAD;
            end
         end
         ST_LOAD:   state_in = ST_COUNT;
         ST_COUNT:  state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (scan_flags.done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // handshake and memory controls
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_RESP);
      accept     = req_tvalid && req_tready;
      scan_start = (state_ff == ST_COUNT);
      tbl_we     = 1'b0;
      tbl_waddr  = free_idx;
      tbl_wdata  = {1'b1, addr_ff};
      cnt_we     = 1'b0;
      for (int k = 0; k < OCTETS; k++) begin
         cnt_addr[k]  = (state_ff == ST_CLEAR) ? clr_ff[CAW-1:0] : octet[k];
         cnt_wdata[k] = cnt_ff[k] + 1'b1;
      end
      case (state_ff)
         ST_CLEAR: begin
            tbl_we    = ({1'b0, clr_ff} < (SW+1)'(TABLE_ENTRIES));
            tbl_waddr = clr_ff[IW-1:0];
            tbl_wdata = '0;
            cnt_we    = ({1'b0, clr_ff} < (SW+1)'(COUNT_DEPTH));
            for (int k = 0; k < OCTETS; k++) begin
               cnt_wdata[k] = '0;
            end
         end
         ST_UPDATE: begin
            if (cmd_ff == CMD_ADD && !scan_flags.hit && scan_flags.free_found) begin
               tbl_we = 1'b1;
               cnt_we = 1'b1;
            end else if (cmd_ff == CMD_DELETE && scan_flags.hit) begin
               tbl_we    = 1'b1;
               tbl_waddr = hit_idx;
               tbl_wdata = {1'b0, addr_ff};
               cnt_we    = 1'b1;
               for (int k = 0; k < OCTETS; k++) begin
                  cnt_wdata[k] = (cnt_ff[k] != '0) ? cnt_ff[k] - 1'b1 : '0;
               end
            end
         end
         default: begin
            tbl_we = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      pass_in       = pass_ff;
      rsp_auth_in   = rsp_auth_ff;
      rsp_pass_in   = rsp_pass_ff;
      rsp_status_in = rsp_status_ff;
      for (int k = 0; k < OCTETS; k++) begin
         cnt_in[k] = cnt_ff[k];
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in        = command_type'(req_tdata[1:0]);
               addr_in       = req_tdata[33:2];
               clr_in        = '0;
               clr_rsp_in    = 1'b1;
               rsp_auth_in   = 1'b0;
               rsp_pass_in   = 1'b0;
               rsp_status_in = STATUS_OK;
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
         end
         ST_COUNT: begin
            pass_in = all_nz;
            for (int k = 0; k < OCTETS; k++) begin
               cnt_in[k] = cnt_rdata[k];
            end
         end
         ST_UPDATE: begin
            case (cmd_ff)
               CMD_ADD: begin
                  if (scan_flags.hit) begin
                     rsp_status_in = STATUS_DUP;
                  end else if (!scan_flags.free_found) begin
                     rsp_status_in = STATUS_FULL;
                  end
               end
               CMD_DELETE: begin
                  if (!scan_flags.hit) begin
                     rsp_status_in = STATUS_NOT_FOUND;
                  end
               end
               CMD_LOOKUP: begin
                  rsp_pass_in = pass_ff;
                  rsp_auth_in = pass_ff && scan_flags.hit;
               end
               default: begin
                  rsp_status_in = STATUS_OK;
               end
            endcase
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      pass_ff       <= pass_in;
      rsp_auth_ff   <= rsp_auth_in;
      rsp_pass_ff   <= rsp_pass_in;
      rsp_status_ff <= rsp_status_in;
      for (int k = 0; k < OCTETS; k++) begin
         cnt_ff[k] <= cnt_in[k];
      end
   end

   assign rsp_tdata = {4'b0000, rsp_status_ff, rsp_pass_ff, rsp_auth_ff};

   // address table
   aalp_ram #(
      .WIDTH (ADDR_W + 1),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   // per-octet counters
   for (genvar g = 0; g < OCTETS; g++) begin : g_count
      aalp_ram #(
         .WIDTH (CW),
         .DEPTH (COUNT_DEPTH)
      ) u_count (
         .clock (clock),
         .we    (cnt_we),
         .waddr (cnt_addr[g]),
         .wdata (cnt_wdata[g]),
         .raddr (cnt_addr[g]),
         .rdata (cnt_rdata[g])
      );
   end

   // table scan unit
   aalp_scan #(
      .ENTRIES (TABLE_ENTRIES)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .start         (scan_start),
      .entry_valid   (tbl_rdata[ADDR_W]),
      .entry_address (tbl_rdata[ADDR_W-1:0]),
      .target        (addr_ff),
      .rd_addr       (tbl_raddr),
      .hit_idx       (hit_idx),
      .free_idx      (free_idx),
      .flags         (scan_flags)
   );

endmodule
